// ===== src/trilinear_volume_resampler_macros.svh =====
// assertion macros for the trilinear volume resampler
// included by files that carry concurrent checks; no other dependencies
`ifndef TRILINEAR_VOLUME_RESAMPLER_MACROS_SVH
`define TRILINEAR_VOLUME_RESAMPLER_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define TVR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define TVR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TVR_ASSERT(lbl, clk, rst_n, prop, msg)
`define TVR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/tvr_pkg.sv =====
// shared types, constants and helpers of the trilinear volume resampler
// no dependencies
`default_nettype none

package tvr_pkg;

  localparam int ADDR_W      = 18;           // volume store address
  localparam int STORE_DEPTH = 262144;
  localparam int VOX_W       = 8;
  localparam int REG_W       = 21;           // signed q12.8 registers
  localparam int IDX_W       = 8;            // output grid index
  localparam int POS_W       = 30;           // origin + step * index, q.8
  localparam int FLR_W       = 23;           // floor plus one, signed
  localparam int CRD_W       = 10;           // clamped voxel coordinate
  localparam int DIM_W       = 11;           // dimension up to 1024
  localparam int WGT_W       = 9;            // axis weight, 0..256
  localparam int WXY_W       = 17;           // product of two axis weights
  localparam int W3_W        = 25;           // product of three axis weights
  localparam int ACC_W       = 32;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_STEP_X   = 3'd3,
    REG_STEP_Y   = 3'd4,
    REG_STEP_Z   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic pos_en;   // latch position at request accept
    logic clp_en;   // split and clamp
    logic trm_en;   // form address terms
  } axis_ctl_t;

  typedef struct packed {
    logic [ADDR_W-1:0] term_lo;
    logic [ADDR_W-1:0] term_hi;
    logic [WGT_W-1:0]  w_lo;
    logic [WGT_W-1:0]  w_hi;
  } axis_out_t;

  // clamp a signed corner coordinate to [0, dim-1]
  function automatic logic [CRD_W-1:0] clamp_coord(input logic signed [FLR_W-1:0] v,
                                                   input logic [DIM_W-1:0] dim);
    logic signed [FLR_W-1:0] dim_s;
    logic [CRD_W-1:0]        res;
    dim_s = $signed({{(FLR_W-DIM_W){1'b0}}, dim});
    if (v <= 0) begin
      res = '0;
    end else if (v >= dim_s) begin
      res = CRD_W'(dim - DIM_W'(1));
    end else begin
      res = v[CRD_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/tvr_ram.sv =====
// generic single-port ram with registered read data
// no dependencies
`default_nettype none

module tvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== src/tvr_axis.sv =====
// one axis of the sample position: position, floor/fraction split, clamp, address terms
// depends on tvr_pkg
`default_nettype none

module tvr_axis
  import tvr_pkg::*;
#(
  parameter int DIM    = 64,
  parameter int STRIDE = 1
) (
  input  logic                    clk_i,
  input  axis_ctl_t               ctl_i,
  input  logic signed [REG_W-1:0] org_i,
  input  logic signed [REG_W-1:0] step_i,
  input  logic [IDX_W-1:0]        idx_i,
  output axis_out_t               axis_o
);

  localparam logic [DIM_W-1:0]  DIM_C    = DIM_W'(DIM);
  localparam logic [ADDR_W-1:0] STRIDE_C = ADDR_W'(STRIDE);

  logic signed [POS_W-1:0] pos_d, pos_q;
  logic signed [FLR_W-1:0] flo, fhi;
  logic [CRD_W-1:0]        crd_lo_q, crd_hi_q;
  logic [WGT_W-1:0]        w_lo_q, w_hi_q;
  logic [ADDR_W-1:0]       term_lo_q, term_hi_q;

  assign pos_d = POS_W'(step_i) * POS_W'($signed({1'b0, idx_i})) + POS_W'(org_i);

  // arithmetic shift keeps floor toward minus infinity
  assign flo = FLR_W'($signed(pos_q[POS_W-1:8]));
  assign fhi = flo + FLR_W'(1);

  always_ff @(posedge clk_i) begin
    if (ctl_i.pos_en) begin
      pos_q <= pos_d;
    end
    if (ctl_i.clp_en) begin
      crd_lo_q <= clamp_coord(flo, DIM_C);
      crd_hi_q <= clamp_coord(fhi, DIM_C);
      w_lo_q   <= WGT_W'(9'd256 - {1'b0, pos_q[7:0]});
      w_hi_q   <= {1'b0, pos_q[7:0]};
    end
    if (ctl_i.trm_en) begin
      // product wraps modulo the store depth
      term_lo_q <= ADDR_W'(ADDR_W'(crd_lo_q) * STRIDE_C);
      term_hi_q <= ADDR_W'(ADDR_W'(crd_hi_q) * STRIDE_C);
    end
  end

  assign axis_o.term_lo = term_lo_q;
  assign axis_o.term_hi = term_hi_q;
  assign axis_o.w_lo    = w_lo_q;
  assign axis_o.w_hi    = w_hi_q;

endmodule

`default_nettype wire

// ===== src/trilinear_volume_resampler.sv =====
// top level of the trilinear volume resampler: apb registers, control and accumulation
// depends on tvr_pkg, tvr_axis, tvr_ram and trilinear_volume_resampler_macros.svh
`default_nettype none
`include "trilinear_volume_resampler_macros.svh"

// A byte volume lives in one single-port memory of 262144 entries. A load beat
// (req_type 0) writes one voxel in the accept cycle and keeps busy low, so loads
// can stream one per cycle. A sample beat (req_type 1) raises busy while it runs
// its steps in order: split each axis position into floor and fraction and clamp
// the corners, form the address terms and the xy weight products, read the eight
// corner voxels through the single memory port, and close the weighted sum. The
// result is on sample_value_o when sample_valid_o is high for exactly one cycle;
// sample_value_o then holds it until the next sample closes. The receiver cannot
// stall it, so it must take the beat when the strobe is high. A new beat can be
// accepted in that same cycle. The user must write registers over apb only
// while idle; the block itself does not enforce it. Reading a voxel that was
// never loaded returns an undefined value.
module trilinear_volume_resampler
  import tvr_pkg::*;
#(
  parameter int SRC_X = 64,
  parameter int SRC_Y = 64,
  parameter int SRC_Z = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic               req_type_i,
  input  logic [ADDR_W-1:0]  load_addr_i,
  input  logic [VOX_W-1:0]   load_byte_i,
  input  logic [IDX_W-1:0]   out_i_i,
  input  logic [IDX_W-1:0]   out_j_i,
  input  logic [IDX_W-1:0]   out_k_i,
  // result side
  output logic               sample_valid_o,
  output logic [VOX_W-1:0]   sample_value_o,
  // apb configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int NUM_CORNERS = 8;
  localparam int CNT_W       = $clog2(NUM_CORNERS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_CORNERS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLP,
    S_TRM,
    S_RD,
    S_FIN
  } state_e;

  state_e                  state_q;
  logic [CNT_W-1:0]        rd_cnt_q;

  logic signed [REG_W-1:0] origin_x_q, origin_y_q, origin_z_q;
  logic signed [REG_W-1:0] step_x_q, step_y_q, step_z_q;

  logic                    accept, smp_accept, ram_we, cfg_wr;
  axis_ctl_t               axis_ctl;
  axis_out_t               ax_x, ax_y, ax_z;

  logic [ADDR_W-1:0]       rd_addr, ram_addr;
  logic [VOX_W-1:0]        ram_rdata;

  logic [WXY_W-1:0]        wxy_q [4];
  logic [W3_W-1:0]         wcur_q;
  logic                    rd_vld_q;
  logic [ACC_W-1:0]        acc_q, prod, sum;

  // corner select bits: x is the slowest, z the fastest
  logic                    sel_x, sel_y, sel_z;

  assign busy       = (state_q != S_IDLE);
  assign accept     = start && !busy;
  assign smp_accept = accept && req_type_i;
  assign ram_we     = accept && !req_type_i;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  // ---------------------------------------------------------------- config regs

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      step_x_q   <= REG_W'(256);
      step_y_q   <= REG_W'(256);
      step_z_q   <= REG_W'(256);
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[4:2]))
        REG_ORIGIN_X: origin_x_q <= $signed(pwdata[REG_W-1:0]);
        REG_ORIGIN_Y: origin_y_q <= $signed(pwdata[REG_W-1:0]);
        REG_ORIGIN_Z: origin_z_q <= $signed(pwdata[REG_W-1:0]);
        REG_STEP_X:   step_x_q   <= $signed(pwdata[REG_W-1:0]);
        REG_STEP_Y:   step_y_q   <= $signed(pwdata[REG_W-1:0]);
        REG_STEP_Z:   step_z_q   <= $signed(pwdata[REG_W-1:0]);
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  // reads come back sign extended to the bus width
  always_comb begin
    unique case (cfg_reg_e'(paddr[4:2]))
      REG_ORIGIN_X: prdata = PDATA_W'(origin_x_q);
      REG_ORIGIN_Y: prdata = PDATA_W'(origin_y_q);
      REG_ORIGIN_Z: prdata = PDATA_W'(origin_z_q);
      REG_STEP_X:   prdata = PDATA_W'(step_x_q);
      REG_STEP_Y:   prdata = PDATA_W'(step_y_q);
      REG_STEP_Z:   prdata = PDATA_W'(step_z_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- axis units

  // position is formed straight from the command ports at the accept edge
  assign axis_ctl.pos_en = smp_accept;
  assign axis_ctl.clp_en = (state_q == S_CLP);
  assign axis_ctl.trm_en = (state_q == S_TRM);

  tvr_axis #(.DIM(SRC_X), .STRIDE(1)) u_axis_x (
    .clk_i  (clk_i),
    .ctl_i  (axis_ctl),
    .org_i  (origin_x_q),
    .step_i (step_x_q),
    .idx_i  (out_i_i),
    .axis_o (ax_x)
  );

  tvr_axis #(.DIM(SRC_Y), .STRIDE(SRC_X)) u_axis_y (
    .clk_i  (clk_i),
    .ctl_i  (axis_ctl),
    .org_i  (origin_y_q),
    .step_i (step_y_q),
    .idx_i  (out_j_i),
    .axis_o (ax_y)
  );

  tvr_axis #(.DIM(SRC_Z), .STRIDE(SRC_X * SRC_Y)) u_axis_z (
    .clk_i  (clk_i),
    .ctl_i  (axis_ctl),
    .org_i  (origin_z_q),
    .step_i (step_z_q),
    .idx_i  (out_k_i),
    .axis_o (ax_z)
  );

  // ---------------------------------------------------------------- corner reads

  assign sel_x = rd_cnt_q[2];
  assign sel_y = rd_cnt_q[1];
  assign sel_z = rd_cnt_q[0];

  assign rd_addr = (sel_x ? ax_x.term_hi : ax_x.term_lo)
                 + (sel_y ? ax_y.term_hi : ax_y.term_lo)
                 + (sel_z ? ax_z.term_hi : ax_z.term_lo);

  // loads only happen while idle, so the port is free for them then
  assign ram_addr = busy ? rd_addr : load_addr_i;

  tvr_ram #(.WIDTH(VOX_W), .DEPTH(STORE_DEPTH)) u_volume (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (load_byte_i),
    .rdata_o (ram_rdata)
  );

  // weights: xy products once per sample, then one z product per read, registered
  // like the memory read data so it lines up with the voxel coming back
  always_ff @(posedge clk_i) begin
    if (state_q == S_TRM) begin
      wxy_q[0] <= WXY_W'(ax_x.w_lo * ax_y.w_lo);
      wxy_q[1] <= WXY_W'(ax_x.w_lo * ax_y.w_hi);
      wxy_q[2] <= WXY_W'(ax_x.w_hi * ax_y.w_lo);
      wxy_q[3] <= WXY_W'(ax_x.w_hi * ax_y.w_hi);
    end
    if (state_q == S_RD) begin
      wcur_q <= W3_W'(wxy_q[rd_cnt_q[2:1]] * (sel_z ? ax_z.w_hi : ax_z.w_lo));
    end
  end

  // total never exceeds 255 * 2^24, so 32 bits hold it exactly
  assign prod = ACC_W'(ram_rdata * wcur_q);
  assign sum  = acc_q + prod;

  always_ff @(posedge clk_i) begin
    if (state_q == S_TRM) begin
      acc_q <= '0;
    end else if (rd_vld_q) begin
      acc_q <= sum;
    end
  end

  // ---------------------------------------------------------------- control

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      rd_cnt_q       <= '0;
      rd_vld_q       <= 1'b0;
      sample_valid_o <= 1'b0;
      sample_value_o <= '0;
    end else begin
      rd_vld_q       <= (state_q == S_RD);
      sample_valid_o <= (state_q == S_FIN);
      unique case (state_q)
        S_IDLE: begin
          if (smp_accept) begin
            state_q <= S_CLP;
          end
        end
        S_CLP: begin
          state_q <= S_TRM;
        end
        S_TRM: begin
          rd_cnt_q <= '0;
          state_q  <= S_RD;
        end
        S_RD: begin
          rd_cnt_q <= rd_cnt_q + CNT_W'(1);
          if (rd_cnt_q == CNT_LAST) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          // last corner closes the sum; top byte is the integer part of the q8.24 sum
          sample_value_o <= sum[ACC_W-1:ACC_W-VOX_W];
          state_q        <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- checks

  `TVR_ASSERT(a_fin_gives_result, clk_i, rst_ni, (state_q == S_FIN) |=> sample_valid_o, "sum closed without a result beat")
  `TVR_ASSERT(a_result_after_fin, clk_i, rst_ni, sample_valid_o |-> $past(state_q == S_FIN), "result beat without a closed sum")
  `TVR_ASSERT_NEVER(a_no_load_in_read, clk_i, rst_ni, ram_we && busy, "volume write during corner reads")
  `TVR_ASSERT(a_read_data_origin, clk_i, rst_ni, rd_vld_q |-> $past(state_q == S_RD), "voxel accumulated without a corner read")

endmodule

`default_nettype wire
